>>> hw/rtl/fdc_pkg.sv
// Package for the frame deframer with CRC-32C checks.
// Holds the header layout constants, status and register codes, the item and result
// types and the byte-wise CRC-32C update; no dependencies.
package fdc_pkg;

    localparam int          HEADER_BYTES = 20;
    localparam int          POS_W        = 5;
    localparam int          CFG_IDX_W    = 2;
    localparam int          CFG_DATA_W   = 32;

    localparam logic [POS_W-1:0] POS_MAGIC_LAST = POS_W'(3);
    localparam logic [POS_W-1:0] POS_VER_FIRST  = POS_W'(4);
    localparam logic [POS_W-1:0] POS_KIND_FIRST = POS_W'(6);
    localparam logic [POS_W-1:0] POS_LEN_FIRST  = POS_W'(8);
    localparam logic [POS_W-1:0] POS_HCRC_FIRST = POS_W'(HEADER_BYTES - 8);
    localparam logic [POS_W-1:0] POS_PCRC_FIRST = POS_W'(HEADER_BYTES - 4);
    localparam logic [POS_W-1:0] POS_LAST       = POS_W'(HEADER_BYTES - 1);
    localparam logic [POS_W-1:0] POS_END        = POS_W'(HEADER_BYTES);

    localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAGIC_WORD       = 2'd0,
        CFG_PROTOCOL_VERSION = 2'd1,
        CFG_KIND_LIMIT       = 2'd2,
        CFG_PAYLOAD_CEILING  = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_MAGIC       = 3'd1,
        ST_VERSION     = 3'd2,
        ST_KIND        = 3'd3,
        ST_TOO_LARGE   = 3'd4,
        ST_HEADER_CRC  = 3'd5,
        ST_PAYLOAD_CRC = 3'd6
    } t_status;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       restart;
    } t_item;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic        frame_done;
        t_status     status;
        logic [15:0] frame_kind;
        logic [15:0] frame_version;
        logic [31:0] payload_length;
    } t_result;

    function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> hw/rtl/fdc_in_if.sv
// Input channel of the frame deframer: one stream byte and a restart flag per transfer.
// Standalone interface with source and sink modports; no dependencies.
interface fdc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       restart;

    modport source (output valid, output in_byte, output restart, input ready);
    modport sink   (input valid, input in_byte, input restart, output ready);
endinterface

>>> hw/rtl/fdc_out_if.sv
// Result channel of the frame deframer: payload byte, done status and header fields.
// Standalone interface with source and sink modports; no dependencies.
interface fdc_out_if;
    logic        valid;
    logic        ready;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        frame_done;
    logic [2:0]  status;
    logic [15:0] frame_kind;
    logic [15:0] frame_version;
    logic [31:0] payload_length;

    modport source (output valid, output payload_valid, output payload_byte,
                    output frame_done, output status, output frame_kind,
                    output frame_version, output payload_length, input ready);
    modport sink   (input valid, input payload_valid, input payload_byte,
                    input frame_done, input status, input frame_kind,
                    input frame_version, input payload_length, output ready);
endinterface

>>> hw/rtl/fdc_in_stage.sv
// Input register of the frame deframer; holds one accepted byte for the parser.
// Depends on fdc_pkg and fdc_in_if.
module fdc_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fdc_in_if.sink        i_rx,
    input  logic          i_pop,
    output logic          o_valid,
    output fdc_pkg::t_item o_item
);
    import fdc_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign i_rx.ready = !r_valid || i_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_item <= '{in_byte: i_rx.in_byte, restart: i_rx.restart};
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

>>> hw/rtl/fdc_parser.sv
// Header parser, CRC-32C checker and configuration registers of the frame deframer.
// Processes one byte per cycle into the result register while that register can take a result. Depends on fdc_pkg.
module fdc_parser (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [fdc_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [fdc_pkg::CFG_DATA_W-1:0]        i_cfg_wdata,
    input  logic                                  i_valid,
    input  fdc_pkg::t_item                        i_item,
    input  logic                                  i_free,
    output logic                                  o_pop,
    output logic                                  o_push,
    output fdc_pkg::t_result                      o_result
);
    import fdc_pkg::*;

    logic [31:0]      r_magic_word;
    logic [15:0]      r_protocol_version;
    logic [15:0]      r_kind_limit;
    logic [31:0]      r_payload_ceiling;

    logic [POS_W-1:0] r_hdr_pos,     n_hdr_pos;
    logic [31:0]      r_remaining,   n_remaining;
    logic             r_in_payload,  n_in_payload;
    logic             r_halted,      n_halted;
    logic [31:0]      r_crc,         n_crc;
    logic [31:0]      r_magic,       n_magic;
    logic [15:0]      r_version,     n_version;
    logic [15:0]      r_kind,        n_kind;
    logic [31:0]      r_length,      n_length;
    logic [31:0]      r_hcrc,        n_hcrc;
    logic [31:0]      r_pcrc,        n_pcrc;

    logic [POS_W-1:0] pos;
    logic [4:0]       lane;
    logic [7:0]       b;
    logic             emit;
    logic             emit_pv;
    logic             emit_done;
    t_status          emit_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic_word       <= '0;
            r_protocol_version <= '0;
            r_kind_limit       <= 16'hFFFF;
            r_payload_ceiling  <= ALL_ONES;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_MAGIC_WORD:       r_magic_word       <= i_cfg_wdata;
                CFG_PROTOCOL_VERSION: r_protocol_version <= i_cfg_wdata[15:0];
                CFG_KIND_LIMIT:       r_kind_limit       <= i_cfg_wdata[15:0];
                CFG_PAYLOAD_CEILING:  r_payload_ceiling  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_pop = i_valid && i_free;
    assign b     = i_item.in_byte;

    always_comb begin
        n_hdr_pos    = r_hdr_pos;
        n_remaining  = r_remaining;
        n_in_payload = r_in_payload;
        n_halted     = r_halted;
        n_crc        = r_crc;
        n_magic      = r_magic;
        n_version    = r_version;
        n_kind       = r_kind;
        n_length     = r_length;
        n_hcrc       = r_hcrc;
        n_pcrc       = r_pcrc;
        pos          = '0;
        lane         = '0;
        emit         = 1'b0;
        emit_pv      = 1'b0;
        emit_done    = 1'b0;
        emit_status  = ST_OK;

        if (i_item.restart) begin
            n_hdr_pos    = '0;
            n_remaining  = '0;
            n_in_payload = 1'b0;
            n_halted     = 1'b0;
            n_crc        = ALL_ONES;
            n_magic      = '0;
            n_version    = '0;
            n_kind       = '0;
            n_length     = '0;
            n_hcrc       = '0;
            n_pcrc       = '0;
        end

        if (!n_halted) begin
            if (n_in_payload) begin
                n_crc       = crc32c_byte(n_crc, b);
                n_remaining = n_remaining - 32'd1;
                emit        = 1'b1;
                emit_pv     = 1'b1;
                if (n_remaining == '0) begin
                    emit_done    = 1'b1;
                    emit_status  = ((n_crc ^ ALL_ONES) == n_pcrc) ? ST_OK : ST_PAYLOAD_CRC;
                    n_in_payload = 1'b0;
                    n_hdr_pos    = '0;
                    n_halted     = (emit_status != ST_OK);
                end
            end else begin
                if (n_hdr_pos == '0) begin
                    n_crc     = ALL_ONES;
                    n_magic   = '0;
                    n_version = '0;
                    n_kind    = '0;
                    n_length  = '0;
                    n_hcrc    = '0;
                    n_pcrc    = '0;
                end
                pos  = (n_hdr_pos >= POS_END) ? '0 : n_hdr_pos;
                lane = {pos[1:0], 3'b000};
                if (pos < POS_HCRC_FIRST) begin
                    n_crc = crc32c_byte(n_crc, b);
                end
                if (pos < POS_VER_FIRST) begin
                    n_magic = {b, n_magic[31:8]};
                end else if (pos < POS_KIND_FIRST) begin
                    n_version[{pos[0], 3'b000} +: 8] = b;
                end else if (pos < POS_LEN_FIRST) begin
                    n_kind[{pos[0], 3'b000} +: 8] = b;
                end else if (pos < POS_HCRC_FIRST) begin
                    n_length[lane +: 8] = b;
                end else if (pos < POS_PCRC_FIRST) begin
                    n_hcrc[lane +: 8] = b;
                end else begin
                    n_pcrc[lane +: 8] = b;
                end
                n_hdr_pos = pos + POS_W'(1);

                if (pos == POS_MAGIC_LAST && n_magic != r_magic_word) begin
                    emit        = 1'b1;
                    emit_done   = 1'b1;
                    emit_status = ST_MAGIC;
                end else if (pos == POS_LAST) begin
                    emit_done = 1'b1;
                    if (n_version != r_protocol_version) begin
                        emit_status = ST_VERSION;
                    end else if (n_kind > r_kind_limit) begin
                        emit_status = ST_KIND;
                    end else if (n_length > r_payload_ceiling) begin
                        emit_status = ST_TOO_LARGE;
                    end else if ((n_crc ^ ALL_ONES) != n_hcrc) begin
                        emit_status = ST_HEADER_CRC;
                    end
                    if (emit_status != ST_OK) begin
                        emit = 1'b1;
                    end else begin
                        n_crc     = ALL_ONES;
                        n_hdr_pos = '0;
                        if (n_length == '0) begin
                            emit        = 1'b1;
                            emit_status = (n_pcrc == '0) ? ST_OK : ST_PAYLOAD_CRC;
                        end else begin
                            emit_done    = 1'b0;
                            n_remaining  = n_length;
                            n_in_payload = 1'b1;
                        end
                    end
                end
                if (emit && emit_status != ST_OK) begin
                    n_halted     = 1'b1;
                    n_in_payload = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_pos    <= '0;
            r_remaining  <= '0;
            r_in_payload <= 1'b0;
            r_halted     <= 1'b0;
            r_crc        <= ALL_ONES;
            r_magic      <= '0;
            r_version    <= '0;
            r_kind       <= '0;
            r_length     <= '0;
            r_hcrc       <= '0;
            r_pcrc       <= '0;
        end else if (o_pop) begin
            r_hdr_pos    <= n_hdr_pos;
            r_remaining  <= n_remaining;
            r_in_payload <= n_in_payload;
            r_halted     <= n_halted;
            r_crc        <= n_crc;
            r_magic      <= n_magic;
            r_version    <= n_version;
            r_kind       <= n_kind;
            r_length     <= n_length;
            r_hcrc       <= n_hcrc;
            r_pcrc       <= n_pcrc;
        end
    end

    assign o_push = o_pop && emit;

    always_comb begin
        o_result.payload_valid  = emit_pv;
        o_result.payload_byte   = emit_pv ? b : 8'd0;
        o_result.frame_done     = emit_done;
        o_result.status         = emit_done ? emit_status : ST_OK;
        o_result.frame_kind     = n_kind;
        o_result.frame_version  = n_version;
        o_result.payload_length = n_length;
    end

endmodule

>>> hw/rtl/fdc_out_stage.sv
// Result register of the frame deframer; presents one result on the output channel.
// Depends on fdc_pkg and fdc_out_if.
module fdc_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  fdc_pkg::t_result i_result,
    output logic             o_free,
    fdc_out_if.source        o_tx
);
    import fdc_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_free = !r_valid || o_tx.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && o_free) begin
            r_result <= i_result;
        end
    end

    assign o_tx.valid          = r_valid;
    assign o_tx.payload_valid  = r_result.payload_valid;
    assign o_tx.payload_byte   = r_result.payload_byte;
    assign o_tx.frame_done     = r_result.frame_done;
    assign o_tx.status         = r_result.status;
    assign o_tx.frame_kind     = r_result.frame_kind;
    assign o_tx.frame_version  = r_result.frame_version;
    assign o_tx.payload_length = r_result.payload_length;

endmodule

>>> hw/rtl/frame_deframer_crc32c_checker_top.sv
// Top level of the frame deframer with CRC-32C header and payload checks.
// Depends on fdc_pkg, fdc_in_if, fdc_out_if, fdc_in_stage, fdc_parser and fdc_out_stage.
//
// The block takes one stream byte per transfer and sustains one byte per clock cycle
// while the result channel keeps ready high. A byte is held in the input register until
// the parser takes it; its result, if any, is loaded into the result register as the
// parser takes the byte and is then offered on the result channel. A result that
// is held off stalls the parser, so the input register fills and input ready drops. The
// rate is set by the parser state, which includes the one-byte CRC-32C update.
// Header bytes produce no result unless a check fails or the frame has no payload; payload bytes
// are forwarded, and the frame ends with a done result carrying the status and the
// header fields. After a failure every byte is dropped until one arrives with restart
// set. The configuration registers may only be written while no byte is in flight.
module frame_deframer_crc32c_checker_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [fdc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fdc_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    fdc_in_if.sink                         i_rx,
    fdc_out_if.source                      o_tx
);
    import fdc_pkg::*;

    logic    s1_valid;
    t_item   s1_item;
    logic    pop;
    logic    push;
    logic    out_free;
    t_result result;

    fdc_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_pop   (pop),
        .o_valid (s1_valid),
        .o_item  (s1_item)
    );

    fdc_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (s1_valid),
        .i_item      (s1_item),
        .i_free      (out_free),
        .o_pop       (pop),
        .o_push      (push),
        .o_result    (result)
    );

    fdc_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (result),
        .o_free   (out_free),
        .o_tx     (o_tx)
    );

`ifndef ASSERT_OFF
    a_result_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tx.valid |-> (o_tx.payload_valid || o_tx.frame_done))
        else $error("Result transfer carries neither a payload byte nor a done status.");

    a_status_only_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tx.valid && !o_tx.frame_done) |-> (o_tx.status == ST_OK))
        else $error("Nonzero status on a result without frame_done.");

    a_payload_end_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tx.valid && o_tx.payload_valid && o_tx.frame_done)
            |-> (o_tx.status == ST_OK || o_tx.status == ST_PAYLOAD_CRC))
        else $error("Last payload byte reports a header error status.");
`endif

endmodule

>>> bench/testbench.sv
// Self-checking bench for frame_deframer_crc32c_checker_top: builds byte streams of
// good, damaged and cut-off frames and checks every result against an in-bench model.
// Depends on fdc_pkg, fdc_in_if, fdc_out_if and the deframer RTL.
module testbench;
    import fdc_pkg::*;

    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int HOLD_PHASE      = 5;
    localparam int HOLD_CYCLES     = 400;
    localparam int SETTLE_CYCLES   = 8;
    localparam int IDLE_LIMIT      = 50000;

    typedef enum int {
        FRAME_CLEAN        = 0,
        FRAME_BAD_MAGIC    = 1,
        FRAME_BAD_VERSION  = 2,
        FRAME_BAD_KIND     = 3,
        FRAME_OVER_CEILING = 4,
        FRAME_BAD_HCRC     = 5,
        FRAME_BAD_PCRC     = 6,
        FRAME_CUT_HEADER   = 7,
        FRAME_CUT_PAYLOAD  = 8
    } t_frame_flaw;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    fdc_in_if  rx_if ();
    fdc_out_if tx_if ();

    frame_deframer_crc32c_checker_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_rx        (rx_if),
        .o_tx        (tx_if)
    );

    // Register copies and parser state of the deframer model.
    logic [31:0] cfg_magic;
    logic [15:0] cfg_version;
    logic [15:0] cfg_kind_limit;
    logic [31:0] cfg_ceiling;

    int          hdr_pos;
    logic [31:0] bytes_left;
    logic        payload_active;
    logic        halted;
    logic [31:0] crc_acc;
    logic [31:0] magic_seen;
    logic [15:0] version_seen;
    logic [15:0] kind_seen;
    logic [31:0] length_seen;
    logic [31:0] hcrc_seen;
    logic [31:0] pcrc_seen;

    t_item   stream_bytes[$];
    t_result frame_reports_due[$];

    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    int phase_num     = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int frames_built  = 0;
    int frames_clean  = 0;
    int frames_failed = 0;
    int fail_count    = 0;
    int hold_left;
    logic hold_used;
    logic need_restart = 1'b0;

    function automatic logic [31:0] crc32c_next(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            if (c[0] ^ b[i]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic void clear_frame_state();
        hdr_pos        = 0;
        bytes_left     = '0;
        payload_active = 1'b0;
        halted         = 1'b0;
        crc_acc        = '1;
        magic_seen     = '0;
        version_seen   = '0;
        kind_seen      = '0;
        length_seen    = '0;
        hcrc_seen      = '0;
        pcrc_seen      = '0;
    endfunction

    function automatic t_result frame_result(input logic pv, input logic [7:0] pb,
                                             input logic done, input t_status st);
        t_result r;
        r.payload_valid  = pv;
        r.payload_byte   = pv ? pb : 8'h00;
        r.frame_done     = done;
        r.status         = done ? st : ST_OK;
        r.frame_kind     = kind_seen;
        r.frame_version  = version_seen;
        r.payload_length = length_seen;
        return r;
    endfunction

    function automatic t_result abort_frame(input t_status st);
        t_result r;
        r              = frame_result(1'b0, 8'h00, 1'b1, st);
        halted         = 1'b1;
        payload_active = 1'b0;
        return r;
    endfunction

    function automatic t_result close_frame(input logic pv, input logic [7:0] pb);
        t_result r;
        t_status st;
        st             = (~crc_acc == pcrc_seen) ? ST_OK : ST_PAYLOAD_CRC;
        r              = frame_result(pv, pb, 1'b1, st);
        payload_active = 1'b0;
        hdr_pos        = 0;
        if (st != ST_OK) begin
            halted = 1'b1;
        end
        return r;
    endfunction

    // Advances the model by one stream byte; returns 1 when the byte yields a result.
    function automatic bit deframe_byte(input logic [7:0] b, input logic rs,
                                        output t_result res);
        int p;
        res = '0;
        if (rs) begin
            clear_frame_state();
        end
        if (halted) begin
            return 1'b0;
        end
        if (payload_active) begin
            crc_acc    = crc32c_next(crc_acc, b);
            bytes_left = bytes_left - 1;
            if (bytes_left == 0) begin
                res = close_frame(1'b1, b);
            end else begin
                res = frame_result(1'b1, b, 1'b0, ST_OK);
            end
            return 1'b1;
        end
        if (hdr_pos == 0) begin
            clear_frame_state();
        end
        p = hdr_pos;
        if (p >= HEADER_BYTES) begin
            hdr_pos = 0;
            p       = 0;
        end
        if (p < POS_HCRC_FIRST) begin
            crc_acc = crc32c_next(crc_acc, b);
        end
        if (p < POS_VER_FIRST) begin
            magic_seen = {b, magic_seen[31:8]};
        end else if (p < POS_KIND_FIRST) begin
            version_seen[8*(p-POS_VER_FIRST) +: 8] = b;
        end else if (p < POS_LEN_FIRST) begin
            kind_seen[8*(p-POS_KIND_FIRST) +: 8] = b;
        end else if (p < POS_HCRC_FIRST) begin
            length_seen[8*(p-POS_LEN_FIRST) +: 8] = b;
        end else if (p < POS_PCRC_FIRST) begin
            hcrc_seen[8*(p-POS_HCRC_FIRST) +: 8] = b;
        end else begin
            pcrc_seen[8*(p-POS_PCRC_FIRST) +: 8] = b;
        end
        hdr_pos = p + 1;

        if (p == POS_MAGIC_LAST && magic_seen != cfg_magic) begin
            res = abort_frame(ST_MAGIC);
            return 1'b1;
        end
        if (p == POS_LAST) begin
            if (version_seen != cfg_version) begin
                res = abort_frame(ST_VERSION);
                return 1'b1;
            end
            if (kind_seen > cfg_kind_limit) begin
                res = abort_frame(ST_KIND);
                return 1'b1;
            end
            if (length_seen > cfg_ceiling) begin
                res = abort_frame(ST_TOO_LARGE);
                return 1'b1;
            end
            if (~crc_acc != hcrc_seen) begin
                res = abort_frame(ST_HEADER_CRC);
                return 1'b1;
            end
            crc_acc = '1;
            hdr_pos = 0;
            if (length_seen == 0) begin
                res = close_frame(1'b0, 8'h00);
                return 1'b1;
            end
            bytes_left     = length_seen;
            payload_active = 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit field_differs(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic add_item(input logic [7:0] b, input logic rs);
        t_item it;
        it.in_byte = b;
        it.restart = rs;
        stream_bytes.push_back(it);
    endtask

    task automatic add_noise(input int n);
        for (int i = 0; i < n; i++) begin
            add_item(8'($urandom), $urandom_range(15) == 0);
        end
        need_restart = 1'b1;
    endtask

    task automatic add_frame(input t_frame_flaw flaw, input int unsigned max_len);
        logic [7:0]  hdr[HEADER_BYTES];
        logic [7:0]  pay[$];
        logic [31:0] magic;
        logic [15:0] ver;
        logic [15:0] kind;
        logic [31:0] len;
        logic [31:0] lim;
        logic [31:0] crc;
        logic [31:0] hcrc;
        logic [31:0] pcrc;
        int unsigned hdr_len;
        int unsigned pay_len;
        logic        rs;
        magic = cfg_magic;
        ver   = cfg_version;
        kind  = ($urandom_range(4) == 0) ? cfg_kind_limit : 16'($urandom_range(cfg_kind_limit, 0));
        lim   = (cfg_ceiling < max_len) ? cfg_ceiling : max_len;
        len   = ($urandom_range(4) == 0) ? lim : $urandom_range(lim, 0);
        case (flaw)
            FRAME_BAD_MAGIC:   magic ^= $urandom_range(32'hFFFF_FFFF, 1);
            FRAME_BAD_VERSION: ver ^= 16'($urandom_range(16'hFFFF, 1));
            FRAME_BAD_KIND: begin
                if (cfg_kind_limit != 16'hFFFF) begin
                    kind = 16'($urandom_range(16'hFFFF, cfg_kind_limit + 1));
                end
            end
            FRAME_OVER_CEILING: begin
                if (cfg_ceiling != 32'hFFFF_FFFF) begin
                    len = $urandom_range(1) ? cfg_ceiling + 1
                                            : $urandom_range(32'hFFFF_FFFF, cfg_ceiling + 1);
                end
            end
            FRAME_CUT_PAYLOAD: begin
                if (cfg_ceiling > 64) begin
                    len = $urandom_range(cfg_ceiling, 65);
                end
            end
            default: ;
        endcase

        hdr_len = (flaw == FRAME_CUT_HEADER) ? $urandom_range(HEADER_BYTES - 1, 1) : HEADER_BYTES;
        case (flaw)
            FRAME_CLEAN, FRAME_BAD_PCRC: pay_len = len;
            FRAME_CUT_PAYLOAD:           pay_len = (len > 6) ? $urandom_range(6, 1) : len / 2;
            default:                     pay_len = 0;
        endcase

        crc = '1;
        for (int unsigned i = 0; i < pay_len; i++) begin
            pay.push_back(8'($urandom));
            crc = crc32c_next(crc, pay[i]);
        end
        pcrc = ~crc;
        if (flaw == FRAME_BAD_PCRC) begin
            pcrc ^= $urandom_range(32'hFFFF_FFFF, 1);
        end

        for (int i = 0; i < 4; i++) begin
            hdr[i]     = magic[8*i +: 8];
            hdr[8 + i] = len[8*i +: 8];
        end
        hdr[4] = ver[7:0];
        hdr[5] = ver[15:8];
        hdr[6] = kind[7:0];
        hdr[7] = kind[15:8];
        crc = '1;
        for (int i = 0; i < POS_HCRC_FIRST; i++) begin
            crc = crc32c_next(crc, hdr[i]);
        end
        hcrc = ~crc;
        if (flaw == FRAME_BAD_HCRC) begin
            hcrc ^= $urandom_range(32'hFFFF_FFFF, 1);
        end
        for (int i = 0; i < 4; i++) begin
            hdr[POS_HCRC_FIRST + i] = hcrc[8*i +: 8];
            hdr[POS_PCRC_FIRST + i] = pcrc[8*i +: 8];
        end

        rs = need_restart || ($urandom_range(9) == 0);
        for (int unsigned i = 0; i < hdr_len; i++) begin
            add_item(hdr[i], (i == 0) ? rs : 1'b0);
        end
        foreach (pay[i]) begin
            add_item(pay[i], 1'b0);
        end
        need_restart = (flaw != FRAME_CLEAN);
        frames_built++;
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] val);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_MAGIC_WORD:       cfg_magic      = val;
            CFG_PROTOCOL_VERSION: cfg_version    = val[15:0];
            CFG_KIND_LIMIT:       cfg_kind_limit = val[15:0];
            CFG_PAYLOAD_CEILING:  cfg_ceiling    = val;
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        int waited;
        waited = 0;
        @(negedge i_clk);
        while ((stream_bytes.size() != 0 || rx_if.valid || frame_reports_due.size() != 0)
               && waited < IDLE_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        if (waited >= IDLE_LIMIT) begin
            $error("%0d results never arrived", frame_reports_due.size());
            fail_count++;
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1000000;
        $display("frame_deframer_crc32c_checker_top test failed");
        $finish;
    end

    always @(posedge i_clk) begin : drive_bytes
        t_result res;
        t_item   nxt;
        if (!i_rst_n) begin
            rx_if.valid   <= 1'b0;
            rx_if.in_byte <= 8'h00;
            rx_if.restart <= 1'b0;
        end else begin
            if (rx_if.valid && rx_if.ready) begin
                items_sent++;
                if (deframe_byte(rx_if.in_byte, rx_if.restart, res)) begin
                    frame_reports_due.push_back(res);
                end
            end
            if (!rx_if.valid || rx_if.ready) begin
                if (stream_bytes.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    nxt = stream_bytes.pop_front();
                    rx_if.valid   <= 1'b1;
                    rx_if.in_byte <= nxt.in_byte;
                    rx_if.restart <= nxt.restart;
                end else begin
                    rx_if.valid <= 1'b0;
                end
            end
        end
    end

    // A long receiver stall during a payload lets the block fill and push back on its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_used <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_used && phase_num == HOLD_PHASE && tx_if.valid
                     && tx_if.payload_valid) begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : watch_results
        t_result want;
        int      misses;
        if (!i_rst_n) begin
            tx_if.ready <= 1'b0;
        end else begin
            if (tx_if.valid && tx_if.ready) begin
                results_seen++;
                if (frame_reports_due.size() == 0) begin
                    $error("result transfer with no result expected");
                    fail_count++;
                end else begin
                    want   = frame_reports_due.pop_front();
                    misses = field_differs("payload_valid", want.payload_valid, tx_if.payload_valid)
                           + field_differs("payload_byte", want.payload_byte, tx_if.payload_byte)
                           + field_differs("frame_done", want.frame_done, tx_if.frame_done)
                           + field_differs("status", want.status, tx_if.status)
                           + field_differs("frame_kind", want.frame_kind, tx_if.frame_kind)
                           + field_differs("frame_version", want.frame_version,
                                           tx_if.frame_version)
                           + field_differs("payload_length", want.payload_length,
                                           tx_if.payload_length);
                    if (misses != 0) begin
                        fail_count++;
                    end
                    if (want.frame_done) begin
                        if (want.status == ST_OK) begin
                            frames_clean++;
                        end else begin
                            frames_failed++;
                        end
                    end
                end
            end
            tx_if.ready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial begin : run_phases
        int          pick;
        t_frame_flaw flaw;
        i_rst_n       = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = CFG_MAGIC_WORD;
        cfg_wdata     = '0;
        rx_if.valid   = 1'b0;
        rx_if.in_byte = 8'h00;
        rx_if.restart = 1'b0;
        tx_if.ready   = 1'b0;
        cfg_magic      = '0;
        cfg_version    = '0;
        cfg_kind_limit = 16'hFFFF;
        cfg_ceiling    = 32'hFFFF_FFFF;
        clear_frame_state();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Opening stream: an empty frame, a bad magic, then a byte dropped while halted.
        @(negedge i_clk);
        add_frame(FRAME_CLEAN, 0);
        add_item(8'hFF, 1'b1);
        repeat (3) add_item(8'hFF, 1'b0);
        add_item(8'h00, 1'b0);
        need_restart = 1'b1;

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            case (phase)
                0: ;
                1: begin
                    write_reg(CFG_MAGIC_WORD, $urandom);
                    write_reg(CFG_PROTOCOL_VERSION, $urandom);
                    write_reg(CFG_KIND_LIMIT, $urandom);
                    write_reg(CFG_PAYLOAD_CEILING, $urandom_range(40));
                end
                2: begin
                    write_reg(CFG_MAGIC_WORD, 32'hFFFF_FFFF);
                    write_reg(CFG_PROTOCOL_VERSION, 32'h0000_FFFF);
                    write_reg(CFG_KIND_LIMIT, 32'h0000_FFFF);
                    write_reg(CFG_PAYLOAD_CEILING, 32'hFFFF_FFFF);
                end
                3: begin
                    write_reg(CFG_MAGIC_WORD, 32'h0);
                    write_reg(CFG_PROTOCOL_VERSION, 32'h0);
                    write_reg(CFG_KIND_LIMIT, 32'h0);
                    write_reg(CFG_PAYLOAD_CEILING, 32'h0);
                end
                default: begin
                    write_reg(CFG_MAGIC_WORD, $urandom);
                    write_reg(CFG_PROTOCOL_VERSION, $urandom);
                    write_reg(CFG_KIND_LIMIT, $urandom);
                    write_reg(CFG_PAYLOAD_CEILING, (phase == HOLD_PHASE)
                                                   ? $urandom_range(400, 64)
                                                   : $urandom_range(100));
                end
            endcase

            @(negedge i_clk);
            phase_num = phase;
            case (phase / 2)
                0: begin
                    tx_idle_pct = 16;
                    rx_idle_pct = 81;
                end
                1: begin
                    tx_idle_pct = 81;
                    rx_idle_pct = 16;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            while (stream_bytes.size() < ITEMS_PER_PHASE) begin
                pick = $urandom_range(99);
                if (pick >= 95) begin
                    add_noise($urandom_range(8, 1));
                end else begin
                    flaw = (pick < 55) ? FRAME_CLEAN : t_frame_flaw'(1 + (pick - 55) / 5);
                    add_frame(flaw, (phase == HOLD_PHASE) ? 64
                                    : (($urandom_range(9) == 0) ? 24 : 8));
                end
            end
        end
        wait_idle();

        $display("Sent %0d bytes in %0d frames under %0d register settings and three idle mixes.",
                 items_sent, frames_built, PHASES);
        $display("Checked %0d results; %0d frames closed clean and %0d with an error status.",
                 results_seen, frames_clean, frames_failed);
        if (fail_count == 0) begin
            $display("frame_deframer_crc32c_checker_top test passed");
        end else begin
            $display("frame_deframer_crc32c_checker_top test failed");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/fdc_pkg.sv
hw/rtl/fdc_in_if.sv
hw/rtl/fdc_out_if.sv
hw/rtl/fdc_in_stage.sv
hw/rtl/fdc_parser.sv
hw/rtl/fdc_out_stage.sv
hw/rtl/frame_deframer_crc32c_checker_top.sv
bench/testbench.sv
